// ----- rtl/imgdec_pkg.sv -----
// ----------------------------------------------------------------------------
// imgdec_pkg
// Types, constants and helpers shared by the image file to RGB565 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package imgdec_pkg;

  localparam int PIXELS_DEF      = 4096;
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = 8;

  localparam logic [7:0] HDR_24 = 8'd24;
  localparam logic [7:0] HDR_16 = 8'd16;
  localparam logic [7:0] HDR_8  = 8'd8;

  localparam logic [13:0] LEGACY_TOTAL = 14'd12288;
  localparam logic [13:0] COUNT_MAX    = 14'd16383;

  localparam logic [1:0] PH_HDR  = 2'd0;
  localparam logic [1:0] PH_PIX  = 2'd1;
  localparam logic [1:0] PH_LOAD = 2'd2;
  localparam logic [1:0] PH_FULL = 2'd3;

  localparam logic [1:0] FMT_24  = 2'd0;
  localparam logic [1:0] FMT_16  = 2'd1;
  localparam logic [1:0] FMT_PAL = 2'd2;
  localparam logic [1:0] FMT_LEG = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SHORT   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam int OQ_AW    = 2;
  localparam int OQ_DEPTH = 1 << OQ_AW;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] pixel_index;
    logic [15:0] color;
    logic [1:0]  status;
    logic [1:0]  format_seen;
    logic        done_res;
  } out_beat_t;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
    logic [15:0]       data;
  } pal_wr_t;

  typedef struct packed {
    logic one;
    logic two;
  } push_t;

  function automatic logic [15:0] to565(input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/imgdec_palette.sv -----
// ----------------------------------------------------------------------------
// imgdec_palette
// Palette store: one write port, one registered read port with write bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module imgdec_palette (
  input  wire logic                           clk,
  input  wire logic                           rd_en,
  input  wire logic [imgdec_pkg::PAL_AW-1:0]  rd_addr,
  input  wire imgdec_pkg::pal_wr_t            wr,
  output logic [15:0]                         rd_data
);

  logic [15:0] mem [imgdec_pkg::PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && (wr.addr == rd_addr)) begin
        rd_data <= wr.data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/imgdec_outq.sv -----
// ----------------------------------------------------------------------------
// imgdec_outq
// Result queue: takes up to two results per cycle, hands out one per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module imgdec_outq (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire imgdec_pkg::push_t     push,
  input  wire imgdec_pkg::out_beat_t push_a,
  input  wire imgdec_pkg::out_beat_t push_b,
  output logic                       room,
  output logic                       dst_valid,
  input  wire logic                  dst_ready,
  output imgdec_pkg::out_beat_t      dst_beat
);

  localparam int CW = imgdec_pkg::OQ_AW + 1;

  imgdec_pkg::out_beat_t q [imgdec_pkg::OQ_DEPTH];

  logic [imgdec_pkg::OQ_AW-1:0] wr_ptr;
  logic [imgdec_pkg::OQ_AW-1:0] rd_ptr;
  logic [CW-1:0]                count;
  logic [CW-1:0]                count_next;
  logic [CW-1:0]                after_pop;
  logic                         pop;

  assign pop       = dst_valid && dst_ready;
  assign dst_valid = (count != '0);
  assign dst_beat  = q[rd_ptr];
  assign after_pop = count - CW'(pop);
  assign room      = (after_pop <= CW'(imgdec_pkg::OQ_DEPTH - 2));

  always_comb begin
    count_next = after_pop + CW'(push.one) + CW'(push.two);
  end

  always_ff @(posedge clk) begin
    if (push.one) begin
      q[wr_ptr] <= push_a;
    end
    if (push.two) begin
      q[wr_ptr + imgdec_pkg::OQ_AW'(1)] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + imgdec_pkg::OQ_AW'(push.one) + imgdec_pkg::OQ_AW'(push.two);
      rd_ptr <= rd_ptr + imgdec_pkg::OQ_AW'(pop);
      count  <= count_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/imgdec_core.sv -----
// ----------------------------------------------------------------------------
// imgdec_core
// Input stage and file decoder: format, grouping, palette load, status.
// ----------------------------------------------------------------------------
`default_nettype none

module imgdec_core #(
  parameter int PIXELS = imgdec_pkg::PIXELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  take,
  input  wire imgdec_pkg::in_beat_t  src_beat,
  output logic                       ready,
  input  wire logic                  room,
  input  wire logic [15:0]           pal_data,
  output imgdec_pkg::pal_wr_t        pal_wr,
  output imgdec_pkg::push_t          push,
  output imgdec_pkg::out_beat_t      res_a,
  output imgdec_pkg::out_beat_t      res_b
);

  localparam int PCW = $clog2(PIXELS + 1);

  logic                  stage_valid;
  imgdec_pkg::in_beat_t  stage;
  logic                  advance;

  logic [1:0]                    phase,      phase_next;
  logic [1:0]                    fmt,        fmt_next;
  logic [13:0]                   byte_count, byte_count_next;
  logic [PCW-1:0]                pix_idx,    pix_idx_next;
  logic [imgdec_pkg::PAL_AW-1:0] pal_count,  pal_count_next;
  logic [15:0]                   pending,    pending_next;
  logic [1:0]                    group,      group_next;

  logic        have_pixel;
  logic [15:0] color;
  logic [1:0]  status;
  logic [7:0]  b;
  imgdec_pkg::out_beat_t pix_res;
  imgdec_pkg::out_beat_t st_res;

  assign advance = stage_valid && room;
  assign ready   = !stage_valid || advance;
  assign b       = stage.byte_in;

  always_comb begin
    phase_next      = phase;
    fmt_next        = fmt;
    byte_count_next = byte_count;
    pix_idx_next    = pix_idx;
    pal_count_next  = pal_count;
    pending_next    = pending;
    group_next      = group;
    have_pixel      = 1'b0;
    color           = '0;
    pal_wr          = '0;

    if (phase == imgdec_pkg::PH_HDR) begin
      byte_count_next = 14'd1;
      pix_idx_next    = '0;
      pal_count_next  = '0;
      pending_next    = '0;
      group_next      = 2'd0;
      case (b)
        imgdec_pkg::HDR_24: begin
          fmt_next   = imgdec_pkg::FMT_24;
          phase_next = imgdec_pkg::PH_PIX;
        end
        imgdec_pkg::HDR_16: begin
          fmt_next   = imgdec_pkg::FMT_16;
          phase_next = imgdec_pkg::PH_PIX;
        end
        imgdec_pkg::HDR_8: begin
          fmt_next   = imgdec_pkg::FMT_PAL;
          phase_next = imgdec_pkg::PH_LOAD;
        end
        default: begin
          fmt_next     = imgdec_pkg::FMT_LEG;
          phase_next   = imgdec_pkg::PH_PIX;
          pending_next = {8'd0, b};
          group_next   = 2'd1;
        end
      endcase
    end else begin
      if (byte_count != imgdec_pkg::COUNT_MAX) begin
        byte_count_next = byte_count + 14'd1;
      end
      if (phase == imgdec_pkg::PH_PIX) begin
        if (fmt == imgdec_pkg::FMT_16) begin
          if (group == 2'd0) begin
            pending_next = {8'd0, b};
            group_next   = 2'd1;
          end else begin
            color      = {b, pending[7:0]};
            group_next = 2'd0;
            have_pixel = 1'b1;
          end
        end else if (fmt == imgdec_pkg::FMT_PAL) begin
          color      = pal_data;
          have_pixel = 1'b1;
        end else if (group < 2'd2) begin
          pending_next = {pending[7:0], b};
          group_next   = group + 2'd1;
        end else begin
          color      = imgdec_pkg::to565(pending[15:8], pending[7:0], b);
          group_next = 2'd0;
          have_pixel = 1'b1;
        end
      end else if (phase == imgdec_pkg::PH_LOAD) begin
        if (group < 2'd2) begin
          pending_next = {pending[7:0], b};
          group_next   = group + 2'd1;
        end else begin
          pal_wr.en      = 1'b1;
          pal_wr.addr    = pal_count;
          pal_wr.data    = imgdec_pkg::to565(pending[15:8], pending[7:0], b);
          group_next     = 2'd0;
          pal_count_next = pal_count + imgdec_pkg::PAL_AW'(1);
          if (pal_count == imgdec_pkg::PAL_AW'(imgdec_pkg::PALETTE_ENTRIES - 1)) begin
            phase_next = imgdec_pkg::PH_PIX;
          end
        end
      end
    end

    if (have_pixel) begin
      pix_idx_next = pix_idx + PCW'(1);
      if (pix_idx == PCW'(PIXELS - 1)) begin
        phase_next = imgdec_pkg::PH_FULL;
      end
    end

    if (fmt_next == imgdec_pkg::FMT_LEG) begin
      status = (byte_count_next == imgdec_pkg::LEGACY_TOTAL) ? imgdec_pkg::ST_OK
                                                              : imgdec_pkg::ST_UNKNOWN;
    end else begin
      status = (phase_next == imgdec_pkg::PH_FULL) ? imgdec_pkg::ST_OK
                                                    : imgdec_pkg::ST_SHORT;
    end

    if (stage.last_byte) begin
      phase_next      = imgdec_pkg::PH_HDR;
      byte_count_next = '0;
      pix_idx_next    = '0;
      pal_count_next  = '0;
      pending_next    = '0;
      group_next      = 2'd0;
    end

    if (!advance) begin
      pal_wr.en = 1'b0;
    end
  end

  always_comb begin
    pix_res             = '0;
    pix_res.kind        = imgdec_pkg::KIND_PIXEL;
    pix_res.pixel_index = 12'(pix_idx);
    pix_res.color       = color;
    pix_res.format_seen = fmt_next;

    st_res              = '0;
    st_res.kind         = imgdec_pkg::KIND_STATUS;
    st_res.status       = status;
    st_res.format_seen  = fmt_next;
    st_res.done_res     = 1'b1;

    res_a    = have_pixel ? pix_res : st_res;
    res_b    = st_res;
    push.one = advance && (have_pixel || stage.last_byte);
    push.two = advance && have_pixel && stage.last_byte;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage <= src_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      phase       <= imgdec_pkg::PH_HDR;
      fmt         <= imgdec_pkg::FMT_24;
      byte_count  <= '0;
      pix_idx     <= '0;
      pal_count   <= '0;
      pending     <= '0;
      group       <= 2'd0;
    end else begin
      if (take) begin
        stage_valid <= 1'b1;
      end else if (advance) begin
        stage_valid <= 1'b0;
      end
      if (advance) begin
        phase       <= phase_next;
        fmt         <= fmt_next;
        byte_count  <= byte_count_next;
        pix_idx     <= pix_idx_next;
        pal_count   <= pal_count_next;
        pending     <= pending_next;
        group       <= group_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/image_file_to_rgb565_decoder_top.sv -----
// ----------------------------------------------------------------------------
// image_file_to_rgb565_decoder_top
// Decodes a byte stream of an image file into RGB565 pixels plus a status.
//
//   channel  dir  handshake              beat
//   src      in   src_valid/src_ready    in_beat_t  (byte_in, last_byte)
//   dst      out  dst_valid/dst_ready    out_beat_t (kind .. done_res)
//
// One byte per cycle while the queue has room; a byte is registered in the input
// stage, decoded from there and its results land in a four-entry result queue.
// The last byte of a file that also completes a pixel yields two results and
// takes two dst beats; the queue absorbs this at full src rate.
// Palette lookup reads the palette RAM at accept and uses the held data at decode.
// Synchronous reset clears control state; palette contents are kept.
// src_ready drops only when the result queue lacks room for two results.
// ----------------------------------------------------------------------------
`default_nettype none

module image_file_to_rgb565_decoder_top #(
  parameter int PIXELS = imgdec_pkg::PIXELS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  src_valid,
  output logic                       src_ready,
  input  wire imgdec_pkg::in_beat_t  src_beat,
  output logic                       dst_valid,
  input  wire logic                  dst_ready,
  output imgdec_pkg::out_beat_t      dst_beat
);

  logic                  take;
  logic                  room;
  logic [15:0]           pal_data;
  imgdec_pkg::pal_wr_t   pal_wr;
  imgdec_pkg::push_t     push;
  imgdec_pkg::out_beat_t res_a;
  imgdec_pkg::out_beat_t res_b;

  assign take = src_valid && src_ready;

  imgdec_palette u_palette (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (src_beat.byte_in),
    .wr      (pal_wr),
    .rd_data (pal_data)
  );

  imgdec_core #(
    .PIXELS (PIXELS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .src_beat (src_beat),
    .ready    (src_ready),
    .room     (room),
    .pal_data (pal_data),
    .pal_wr   (pal_wr),
    .push     (push),
    .res_a    (res_a),
    .res_b    (res_b)
  );

  imgdec_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_a    (res_a),
    .push_b    (res_b),
    .room      (room),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_beat  (dst_beat)
  );

`ifndef SYNTHESIS
  a_status_done : assert property (@(posedge clk) disable iff (rst)
    dst_valid && (dst_beat.kind == imgdec_pkg::KIND_STATUS) |-> dst_beat.done_res)
    else $error("status result without done flag");

  a_pixel_clean : assert property (@(posedge clk) disable iff (rst)
    dst_valid && (dst_beat.kind == imgdec_pkg::KIND_PIXEL)
      |-> (dst_beat.status == imgdec_pkg::ST_OK) && !dst_beat.done_res)
    else $error("pixel result carries status or done flag");

  a_status_code : assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> (dst_beat.status != 2'd3))
    else $error("undefined status code");

  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> !dst_valid)
    else $error("result pending right after reset");
`endif

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for the image file to RGB565 decoder. A driver sends files byte by
// byte from a queue, and a decode model predicts the pixel and status beats.
// A monitor checks every output beat against the oldest prediction. Short
// directed files come first, then random short files of every format.
// Both sides stall at random, except during one calm stretch.
// ----------------------------------------------------------------------------
module tb;
  import imgdec_pkg::*;

  localparam int PIXELS     = PIXELS_DEF;
  localparam int DRAIN_WAIT = 16;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      src_valid = 1'b0;
  logic      src_ready;
  in_beat_t  src_beat  = '0;
  logic      dst_valid;
  logic      dst_ready = 1'b0;
  out_beat_t dst_beat;

  image_file_to_rgb565_decoder_top #(.PIXELS(PIXELS)) dut (
    .clk      (clk),
    .rst      (rst),
    .src_valid(src_valid),
    .src_ready(src_ready),
    .src_beat (src_beat),
    .dst_valid(dst_valid),
    .dst_ready(dst_ready),
    .dst_beat (dst_beat)
  );

  always #5 clk = ~clk;

  in_beat_t  file_bytes[$];
  out_beat_t owed_beats[$];
  int        errors    = 0;
  int        cycle_num = 0;
  int        cycle_cap = 0;
  logic      calm;

  assign calm = (cycle_num >= 250) && (cycle_num < 450);

  // decode model state
  logic [1:0]  dec_phase = PH_HDR;
  logic [1:0]  dec_fmt   = FMT_24;
  logic [13:0] byte_cnt  = '0;
  logic [12:0] pix_cnt   = '0;
  logic [15:0] held      = '0;
  logic [1:0]  grp       = '0;
  logic [15:0] palette [PALETTE_ENTRIES];

  task automatic note_error(input string msg);
    if (errors < 100)
      $display("ERROR cycle %0d: %s", cycle_num, msg);
    errors++;
  endtask

  function automatic logic [15:0] rgb_pack(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  task automatic clear_file();
    dec_phase = PH_HDR;
    byte_cnt  = '0;
    pix_cnt   = '0;
    held      = '0;
    grp       = '0;
  endtask

  task automatic owe(input logic kind, input logic [11:0] idx, input logic [15:0] col,
                     input logic [1:0] st, input logic done);
    out_beat_t r;
    r.kind        = kind;
    r.pixel_index = idx;
    r.color       = col;
    r.status      = st;
    r.format_seen = dec_fmt;
    r.done_res    = done;
    owed_beats.push_back(r);
  endtask

  task automatic decode_byte(input in_beat_t beat);
    logic [7:0]  b;
    logic        got;
    logic [15:0] col;
    logic [1:0]  st;
    b   = beat.byte_in;
    got = 1'b0;
    col = '0;
    if (dec_phase == PH_HDR) begin
      clear_file();
      byte_cnt = 14'd1;
      case (b)
        HDR_24: begin
          dec_fmt   = FMT_24;
          dec_phase = PH_PIX;
        end
        HDR_16: begin
          dec_fmt   = FMT_16;
          dec_phase = PH_PIX;
        end
        HDR_8: begin
          dec_fmt   = FMT_PAL;
          dec_phase = PH_LOAD;
        end
        default: begin
          dec_fmt   = FMT_LEG;
          dec_phase = PH_PIX;
          held      = {8'h00, b};
          grp       = 2'd1;
        end
      endcase
    end else begin
      if (byte_cnt < COUNT_MAX)
        byte_cnt++;
      if (dec_phase == PH_PIX) begin
        if (dec_fmt == FMT_16) begin
          if (grp == 2'd0) begin
            held = {8'h00, b};
            grp  = 2'd1;
          end else begin
            col = {b, held[7:0]};
            grp = 2'd0;
            got = 1'b1;
          end
        end else if (dec_fmt == FMT_PAL) begin
          col = palette[b];
          got = 1'b1;
        end else if (grp < 2'd2) begin
          held = {held[7:0], b};
          grp++;
        end else begin
          col = rgb_pack(held[15:8], held[7:0], b);
          grp = 2'd0;
          got = 1'b1;
        end
      end else if (dec_phase == PH_LOAD) begin
        if (grp < 2'd2) begin
          held = {held[7:0], b};
          grp++;
        end else begin
          palette[pix_cnt[7:0]] = rgb_pack(held[15:8], held[7:0], b);
          grp = 2'd0;
          pix_cnt++;
          if (pix_cnt >= PALETTE_ENTRIES) begin
            pix_cnt   = '0;
            dec_phase = PH_PIX;
          end
        end
      end
    end
    if (got) begin
      owe(KIND_PIXEL, pix_cnt[11:0], col, ST_OK, 1'b0);
      pix_cnt++;
      if (pix_cnt >= PIXELS)
        dec_phase = PH_FULL;
    end
    if (beat.last_byte) begin
      if (dec_fmt == FMT_LEG)
        st = (byte_cnt == LEGACY_TOTAL) ? ST_OK : ST_UNKNOWN;
      else
        st = (dec_phase == PH_FULL) ? ST_OK : ST_SHORT;
      owe(KIND_STATUS, '0, '0, st, 1'b1);
      clear_file();
    end
  endtask

  task automatic put_byte(input logic [7:0] b, input logic last);
    in_beat_t beat;
    beat.byte_in   = b;
    beat.last_byte = last;
    file_bytes.push_back(beat);
  endtask

  task automatic queue_file(input logic [1:0] fmt, input int len);
    logic [7:0] head;
    case (fmt)
      FMT_24:  head = HDR_24;
      FMT_16:  head = HDR_16;
      FMT_PAL: head = HDR_8;
      default: begin
        head = 8'($urandom_range(255));
        while (head == HDR_24 || head == HDR_16 || head == HDR_8)
          head = 8'($urandom_range(255));
      end
    endcase
    put_byte(head, len == 1);
    for (int i = 1; i < len; i++)
      put_byte(8'($urandom_range(255)), i == len - 1);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      src_valid <= 1'b0;
    end else if (!src_valid || src_ready) begin
      if (src_valid)
        decode_byte(src_beat);
      if (file_bytes.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
        src_valid <= 1'b1;
        src_beat  <= file_bytes.pop_front();
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      note_error($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // monitor
  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      dst_ready <= 1'b0;
    end else begin
      if (dst_valid && dst_ready) begin
        if (owed_beats.size() == 0) begin
          note_error("beat with nothing expected");
        end else begin
          want = owed_beats.pop_front();
          check_field("kind", dst_beat.kind, want.kind);
          check_field("pixel_index", dst_beat.pixel_index, want.pixel_index);
          check_field("color", dst_beat.color, want.color);
          check_field("status", dst_beat.status, want.status);
          check_field("format_seen", dst_beat.format_seen, want.format_seen);
          check_field("done_res", dst_beat.done_res, want.done_res);
        end
      end
      dst_ready <= calm || ($urandom_range(99) >= 19);
    end
  end

  always @(posedge clk) begin
    cycle_num <= cycle_num + 1;
    if (cycle_num > cycle_cap) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int         total;
    logic [1:0] fmt;
    int         len;

    cycle_cap = cycle_cap + 1;

    // one-byte files of each kind
    put_byte(HDR_24, 1'b1);
    put_byte(HDR_16, 1'b1);
    put_byte(HDR_8, 1'b1);
    put_byte(8'h00, 1'b1);
    put_byte(8'hFF, 1'b1);
    // short 16-bit file with extreme pixels
    put_byte(HDR_16, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b1);
    // short 24-bit file with extreme pixels
    put_byte(HDR_24, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b0);
    put_byte(8'h00, 1'b1);
    // legacy file with one pixel, wrong size
    put_byte(8'hA5, 1'b0);
    put_byte(8'h5A, 1'b0);
    put_byte(8'hC3, 1'b1);
    // short palette file ending mid-load
    put_byte(HDR_8, 1'b0);
    put_byte(8'hFF, 1'b0);
    put_byte(8'h00, 1'b1);

    total = file_bytes.size();
    while (total < 650) begin
      fmt = 2'($urandom_range(3));
      len = 1 + $urandom_range(40);
      queue_file(fmt, len);
      total += len;
    end
    cycle_cap = 10 * file_bytes.size() + 10000;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (file_bytes.size() != 0 || src_valid || owed_beats.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
